// ===== rtl/max_priority_queue_tiebreak_unit_macros.svh =====
// Assertion macros for the max priority queue tiebreak unit.
// Used by the top level; expects a clock named clock and a reset named reset.
`ifndef MAX_PRIORITY_QUEUE_TIEBREAK_UNIT_MACROS_SVH
`define MAX_PRIORITY_QUEUE_TIEBREAK_UNIT_MACROS_SVH

// same-cycle implication
`define MPQTB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MPQTB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mpqtb_pkg.sv =====
// Shared types and constants for the max priority queue tiebreak unit.
// No dependencies.
`timescale 1ns / 1ps

package mpqtb_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_PEEK   = 2'd1;
   localparam logic [1:0] CMD_POP    = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [15:0] roll;
      logic [9:0]  marks;
   } rec_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] roll;
      logic [9:0]  marks;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] best_roll;
      logic [9:0]  best_marks;
   } rsp_type;

endpackage

// ===== rtl/mpqtb_beats.sv =====
// Record compare unit: higher marks wins, lower roll breaks ties.
// Depends on mpqtb_pkg.
`timescale 1ns / 1ps

module mpqtb_beats (
   input  mpqtb_pkg::rec_type cand,
   input  mpqtb_pkg::rec_type incumbent,
   output logic               cand_wins
);
   import mpqtb_pkg::*;

   always_comb begin
      if (cand.marks != incumbent.marks) begin
         cand_wins = (cand.marks > incumbent.marks);
      end else begin
         cand_wins = (cand.roll < incumbent.roll);
      end
   end

endmodule

// ===== rtl/max_priority_queue_tiebreak_unit.sv =====
// Top level of the max priority queue tiebreak unit: sequencer, record store, scan.
// Depends on mpqtb_pkg, mpqtb_beats and max_priority_queue_tiebreak_unit_macros.svh.
//
//   channel   ports                     transfer when
//   request   start, busy, req_data     start high and busy low at clock edge
//   response  rsp_valid, rsp_data       rsp_valid high (one cycle, no backpressure)
//
// Insert and peek scan the stored records once through the single store read port;
// the result is out in the cycle busy falls.
// Pop scans, moves the last record into the hole, then scans again; when the last
// record goes, it answers after the move with no second scan.
// Insert into a full store and peek/pop on an empty store answer without a scan.
// Reset (synchronous) empties the store; no clearing pass. The receiver cannot stall.
`timescale 1ns / 1ps
`include "max_priority_queue_tiebreak_unit_macros.svh"

module max_priority_queue_tiebreak_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  mpqtb_pkg::req_type req_data,
   output logic               rsp_valid,
   output mpqtb_pkg::rsp_type rsp_data
);
   import mpqtb_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_POP_RD,
      S_POP_WR
   } state_type;

   // record store
   rec_type              store_mem [CAPACITY];
   rec_type              rd_data_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   rec_type              mem_wdata;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     scan_addr_ff, scan_addr_in;
   logic                 iss_vld_ff, iss_vld_in;
   logic [IDX_W-1:0]     iss_idx_ff, iss_idx_in;
   rec_type              best_ff, best_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic                 pop_ff, pop_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 cand_wins;
   logic                 take;
   rec_type              best_nxt;
   logic [IDX_W-1:0]     best_idx_nxt;
   logic [CNT_W-1:0]     last_cnt;
   logic                 scan_last;
   logic                 store_full;
   logic                 store_empty;

   mpqtb_beats u_beats (
      .cand      (rd_data_ff),
      .incumbent (best_ff),
      .cand_wins (cand_wins)
   );

   assign last_cnt     = count_ff - CNT_W'(1);
   assign store_full   = (count_ff == CNT_W'(CAPACITY));
   assign store_empty  = (count_ff == '0);
   assign take         = (iss_idx_ff == '0) || cand_wins;
   assign best_nxt     = take ? rd_data_ff : best_ff;
   assign best_idx_nxt = take ? iss_idx_ff : best_idx_ff;
   assign scan_last    = iss_vld_ff && (CNT_W'(iss_idx_ff) == last_cnt);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_addr_in = scan_addr_ff;
      iss_vld_in   = 1'b0;
      iss_idx_in   = iss_idx_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      pop_in       = pop_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = scan_addr_ff[IDX_W-1:0];
      mem_we       = 1'b0;
      mem_waddr    = count_ff[IDX_W-1:0];
      mem_wdata    = '{roll: req_data.roll, marks: req_data.marks};

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               pop_in       = 1'b0;
               scan_addr_in = '0;
               case (req_data.command)
                  CMD_INSERT: begin
                     if (store_full) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{status: ST_FULL, best_roll: '0, best_marks: '0};
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        state_in = S_SCAN;
                     end
                  end
                  CMD_POP: begin
                     if (store_empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{status: ST_EMPTY, best_roll: '0, best_marks: '0};
                     end else begin
                        pop_in   = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     // peek, and the unused code behaves the same
                     if (store_empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{status: ST_EMPTY, best_roll: '0, best_marks: '0};
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            // issue one read per cycle; compare lags by the read register
            if (scan_addr_ff < count_ff) begin
               iss_vld_in   = 1'b1;
               iss_idx_in   = scan_addr_ff[IDX_W-1:0];
               scan_addr_in = scan_addr_ff + CNT_W'(1);
            end
            if (iss_vld_ff) begin
               best_in     = best_nxt;
               best_idx_in = best_idx_nxt;
               if (scan_last) begin
                  if (pop_ff) begin
                     state_in = S_POP_RD;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{status: ST_OK, best_roll: best_nxt.roll,
                                      best_marks: best_nxt.marks};
                     state_in     = S_IDLE;
                  end
               end
            end
         end
         S_POP_RD: begin
            rd_addr  = last_cnt[IDX_W-1:0];
            state_in = S_POP_WR;
         end
         S_POP_WR: begin
            // last record fills the hole of the removed best
            mem_we       = 1'b1;
            mem_waddr    = best_idx_ff;
            mem_wdata    = rd_data_ff;
            count_in     = last_cnt;
            pop_in       = 1'b0;
            scan_addr_in = '0;
            if (last_cnt == '0) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: ST_EMPTY, best_roll: '0, best_marks: '0};
               state_in     = S_IDLE;
            end else begin
               state_in = S_SCAN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         iss_vld_ff   <= 1'b0;
         pop_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iss_vld_ff   <= iss_vld_in;
         pop_ff       <= pop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_addr_ff <= scan_addr_in;
      iss_idx_ff   <= iss_idx_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MPQTB_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `MPQTB_ASSERT_NOW(a_ok_needs_record, rsp_valid && (rsp_data.status == ST_OK),
      count_ff != '0, "record reported from empty store")
   `MPQTB_ASSERT_NEXT(a_insert_grows,
      start && !busy && (req_data.command == CMD_INSERT) && !store_full,
      count_ff == $past(count_ff) + CNT_W'(1), "insert did not add a record")
   `MPQTB_ASSERT_NOW(a_done_responds, $fell(busy), rsp_valid, "operation ended without a result")

endmodule

// ===== tb/sv/max_priority_queue_tiebreak_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for max_priority_queue_tiebreak_unit: directed and random command streams,
// each result checked against an in-bench model of the record store.
// Depends on mpqtb_pkg and the unit's RTL.

module max_priority_queue_tiebreak_unit_tb;
   import mpqtb_pkg::*;

   localparam logic [1:0] CMD_SPARE = 2'd3;  // unused code, behaves as peek
   localparam int RANDOM_ITEMS = 580;        // per idling phase
   localparam int TREND_SPAN = 100;
   localparam int SETTLE_CYCLES = 2 * CAPACITY + 16;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;

   typedef enum int {TREND_FILL, TREND_DRAIN, TREND_MIXED} trend_type;

   class queue_scoreboard;
      rec_type held[CAPACITY];
      int unsigned held_count;
      rsp_type awaited[$];
      int unsigned errors;

      // highest marks wins, lower roll breaks ties
      function int best_slot_index();
         int bi;
         bi = 0;
         for (int i = 1; i < held_count; i++)
            if (held[i].marks > held[bi].marks ||
                (held[i].marks == held[bi].marks && held[i].roll < held[bi].roll))
               bi = i;
         return bi;
      endfunction

      function rsp_type best_report();
         rsp_type r;
         int bi;
         r = '0;
         if (held_count == 0) begin
            r.status = ST_EMPTY;
         end else begin
            bi = best_slot_index();
            r.status = ST_OK;
            r.best_roll = held[bi].roll;
            r.best_marks = held[bi].marks;
         end
         return r;
      endfunction

      function void note_input(req_type item);
         rsp_type r;
         int bi;
         case (item.command)
            CMD_INSERT: begin
               if (held_count >= CAPACITY) begin
                  r = '0;
                  r.status = ST_FULL;
               end else begin
                  held[held_count].roll = item.roll;
                  held[held_count].marks = item.marks;
                  held_count++;
                  r = best_report();
               end
            end
            CMD_POP: begin
               if (held_count != 0) begin
                  bi = best_slot_index();
                  held[bi] = held[held_count - 1];
                  held_count--;
               end
               r = best_report();
            end
            default: r = best_report();
         endcase
         awaited = {awaited, r};
      endfunction

      function void check(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result, expected none, got status %0d roll %0d marks %0d",
                     $time, got.status, got.best_roll, got.best_marks);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.best_roll !== want.best_roll) begin
            $display("%0t: best_roll expected %0d got %0d", $time, want.best_roll, got.best_roll);
            errors++;
         end
         if (got.best_marks !== want.best_marks) begin
            $display("%0t: best_marks expected %0d got %0d", $time, want.best_marks,
                     got.best_marks);
            errors++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   int unsigned cycle_count = 0;
   queue_scoreboard board;

   max_priority_queue_tiebreak_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Both transfers are seen in one process, so an input is always noted before its result.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            board.note_input(req_data);
         if (rsp_valid)
            board.check(rsp_data);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL max_priority_queue_tiebreak_unit");
         $finish;
      end
   end

   function automatic req_type cmd_item(input logic [1:0] command, input logic [15:0] roll,
                                        input logic [9:0] marks);
      req_type item;
      item.command = command;
      item.roll = roll;
      item.marks = marks;
      return item;
   endfunction

   // Small value pools make marks ties and duplicate records common.
   function automatic req_type random_item(input trend_type trend);
      req_type item;
      int unsigned insert_pct;
      int unsigned pick;
      insert_pct = (trend == TREND_FILL) ? 80 : (trend == TREND_DRAIN) ? 25 : 50;
      pick = $urandom_range(99);
      if (pick < insert_pct) begin
         item.command = CMD_INSERT;
      end else begin
         pick = $urandom_range(9);
         item.command = (pick < 7) ? CMD_POP : (pick < 9) ? CMD_PEEK : CMD_SPARE;
      end
      pick = $urandom_range(9);
      item.roll = (pick < 5) ? 16'($urandom_range(7)) :
                  (pick == 5) ? 16'hFFFF - 16'($urandom_range(3)) : 16'($urandom);
      pick = $urandom_range(9);
      item.marks = (pick < 4) ? 10'($urandom_range(3)) :
                   (pick == 4) ? 10'h3FF - 10'($urandom_range(3)) : 10'($urandom);
      return item;
   endfunction

   // Returns at the edge where the transfer happens; start stays high for a following item.
   task automatic send_item(input req_type item, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int idle_pct);
      trend_type trend;
      trend = TREND_FILL;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % TREND_SPAN == 0)
            trend = trend_type'($urandom_range(2));
         send_item(random_item(trend), idle_pct);
      end
   endtask

   initial begin
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty store, every read command
      send_item(cmd_item(CMD_PEEK, 16'h1234, 10'h155), 0);
      send_item(cmd_item(CMD_POP, 16'hFFFF, 10'h3FF), 0);
      send_item(cmd_item(CMD_SPARE, 16'h0000, 10'h000), 0);
      // extremes, marks ties, identical records
      send_item(cmd_item(CMD_INSERT, 16'hFFFF, 10'h3FF), 0);
      send_item(cmd_item(CMD_INSERT, 16'h0000, 10'h000), 0);
      send_item(cmd_item(CMD_INSERT, 16'h0000, 10'h3FF), 0);
      send_item(cmd_item(CMD_INSERT, 16'h0005, 10'h3FF), 0);
      send_item(cmd_item(CMD_INSERT, 16'h0005, 10'h3FF), 0);
      send_item(cmd_item(CMD_PEEK, 16'h0000, 10'h000), 0);
      send_item(cmd_item(CMD_SPARE, 16'hFFFF, 10'h3FF), 0);
      // drain past the last record
      repeat (6) send_item(cmd_item(CMD_POP, 16'h0000, 10'h000), 0);
      send_item(cmd_item(CMD_INSERT, 16'hAAAA, 10'h155), 0);
      send_item(cmd_item(CMD_INSERT, 16'h5555, 10'h2AA), 0);
      send_item(cmd_item(CMD_POP, 16'h5555, 10'h2AA), 0);
      send_item(cmd_item(CMD_POP, 16'hAAAA, 10'h155), 0);
      wait_drained();

      random_phase(13);
      wait_drained();
      random_phase(88);
      wait_drained();
      random_phase(0);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (board.errors == 0 && board.pending() == 0)
         $display("PASS max_priority_queue_tiebreak_unit");
      else
         $display("FAIL max_priority_queue_tiebreak_unit");
      $finish;
   end

endmodule
